>>> sv/sbck_pkg.sv
// ----------------------------------------------------------------------------
// sbck_pkg: shared types for the sprite blitter
// Request and response words, input mode codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbck_pkg;

   typedef enum logic [0:0] {
      MODE_LOAD  = 1'b0,
      MODE_PIXEL = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      CSR_POS_X     = 3'd0,
      CSR_POS_Y     = 3'd1,
      CSR_HOTSPOT_X = 3'd2,
      CSR_HOTSPOT_Y = 3'd3,
      CSR_WIDTH     = 3'd4,
      CSR_HEIGHT    = 3'd5,
      CSR_FLIP      = 3'd6,
      CSR_MASK      = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned DIM_W       = 11;
   localparam int unsigned INDEX_W     = 8;
   localparam int unsigned COLOR_W     = 16;
   localparam int unsigned PALETTE_LEN = 256;

   typedef struct packed {
      mode_type             mode;
      logic [INDEX_W-1:0]   palette_slot;
      logic [COLOR_W-1:0]   palette_value;
      logic [INDEX_W-1:0]   pixel_index;
   } req_type;

   typedef struct packed {
      logic [8:0]           dest_x;
      logic [7:0]           dest_y;
      logic [COLOR_W-1:0]   color;
      logic                 sprite_done;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/sbck_ram.sv
// ----------------------------------------------------------------------------
// sbck_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds while
// the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sbck_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/sprite_blitter_clip_flip_key_unit.sv
// ----------------------------------------------------------------------------
// sprite_blitter_clip_flip_key_unit: palettized sprite blitter
// Loads a 256-entry RGB565 palette and places raster-ordered sprite pixels
// into the framebuffer with clipping, horizontal mirroring and a color key.
//
//   Channel   Direction  Handshake          Word
//   req_      in         valid / stall      palette load or sprite pixel
//   rsp_      out        valid / stall      dest_x, dest_y, color, sprite_done
//   csr_      in         valid / ready      register index and data
//
// One item is accepted per cycle while req_stall is low; a kept pixel passes
// the registered palette read, then the placement logic and the response
// register before it appears on rsp_.
// Reset clears the counters, the key and the registers; palette contents
// are undefined until loaded and need no clearing pass.
// A stalled response holds the pixel stage, which then stalls req_.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blitter_clip_flip_key_unit #(
   parameter int FB_WIDTH       = 320,
   parameter int FB_HEIGHT      = 240,
   parameter int MAX_SPRITE_DIM = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sbck_pkg::req_type     req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sbck_pkg::rsp_type          rsp_payload,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire sbck_pkg::csr_index_type csr_index,
   input  wire logic [sbck_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W   = $clog2(MAX_SPRITE_DIM + 1);
   localparam int COORD_W = ((CNT_W > 16) ? CNT_W : 16) + 2;

   function automatic logic [CNT_W-1:0] eff_dim(input logic [sbck_pkg::DIM_W-1:0] d);
      if (d == '0) begin
         return CNT_W'(1);
      end else if (int'(d) > MAX_SPRITE_DIM) begin
         return CNT_W'(MAX_SPRITE_DIM);
      end else begin
         return CNT_W'(d);
      end
   endfunction

   logic signed [15:0]            pos_x_ff, pos_y_ff, hot_x_ff, hot_y_ff;
   logic [CNT_W-1:0]              width_ff, height_ff;
   logic                          flip_ff, mask_ff;
   logic [CNT_W-1:0]              col_ff, row_ff, col_in, row_in;
   logic [sbck_pkg::INDEX_W-1:0]  key_ff, key_in;
   logic                          a_valid_ff;
   logic [sbck_pkg::INDEX_W-1:0]  a_index_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   sbck_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          adv_out, a_fire, req_accept;
   logic                          is_pixel, is_load;
   logic [sbck_pkg::COLOR_W-1:0]  pal_color;
   logic signed [COORD_W-1:0]     dx, dy, col_ext, row_ext;
   logic signed [COORD_W-1:0]     px_ext, py_ext, hx_ext, hy_ext;
   logic                          first, last_col, done, keep, key_hit;

   assign csr_ready  = 1'b1;
   assign adv_out    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = a_valid_ff && !adv_out;
   assign req_accept = req_valid && !req_stall;
   assign is_pixel   = req_payload.mode == sbck_pkg::MODE_PIXEL;
   assign is_load    = req_payload.mode == sbck_pkg::MODE_LOAD;
   assign a_fire     = a_valid_ff && adv_out;

   sbck_ram #(
      .WIDTH (sbck_pkg::COLOR_W),
      .DEPTH (sbck_pkg::PALETTE_LEN)
   ) u_palette (
      .clock   (clock),
      .wr_en   (req_accept && is_load),
      .wr_addr (req_payload.palette_slot),
      .wr_data (req_payload.palette_value),
      .rd_en   (req_accept && is_pixel),
      .rd_addr (req_payload.pixel_index),
      .rd_data (pal_color)
   );

   always_comb begin
      px_ext  = COORD_W'(pos_x_ff);
      py_ext  = COORD_W'(pos_y_ff);
      hx_ext  = COORD_W'(hot_x_ff);
      hy_ext  = COORD_W'(hot_y_ff);
      col_ext = $signed(COORD_W'(col_ff));
      row_ext = $signed(COORD_W'(row_ff));
      if (flip_ff) begin
         dx = px_ext + hx_ext - COORD_W'(1) - col_ext;
      end else begin
         dx = px_ext - hx_ext + col_ext;
      end
      dy = py_ext - hy_ext + row_ext;

      first    = (col_ff == '0) && (row_ff == '0);
      last_col = ({1'b0, col_ff} + (CNT_W + 1)'(1)) >= {1'b0, width_ff};
      done     = last_col && (({1'b0, row_ff} + (CNT_W + 1)'(1)) >= {1'b0, height_ff});
      key_in   = first ? a_index_ff : key_ff;
      key_hit  = mask_ff && (a_index_ff == key_in);
      keep     = (dx >= 0) && (dx < $signed(COORD_W'(FB_WIDTH)))
              && (dy >= 0) && (dy < $signed(COORD_W'(FB_HEIGHT))) && !key_hit;

      if (last_col) begin
         col_in = '0;
         row_in = done ? '0 : row_ff + CNT_W'(1);
      end else begin
         col_in = col_ff + CNT_W'(1);
         row_in = row_ff;
      end

      rsp_valid_in       = a_valid_ff && keep;
      rsp_in.dest_x      = dx[8:0];
      rsp_in.dest_y      = dy[7:0];
      rsp_in.color       = pal_color;
      rsp_in.sprite_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         hot_x_ff  <= '0;
         hot_y_ff  <= '0;
         width_ff  <= CNT_W'(1);
         height_ff <= CNT_W'(1);
         flip_ff   <= 1'b0;
         mask_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sbck_pkg::CSR_POS_X:     pos_x_ff  <= $signed(csr_data);
            sbck_pkg::CSR_POS_Y:     pos_y_ff  <= $signed(csr_data);
            sbck_pkg::CSR_HOTSPOT_X: hot_x_ff  <= $signed(csr_data);
            sbck_pkg::CSR_HOTSPOT_Y: hot_y_ff  <= $signed(csr_data);
            sbck_pkg::CSR_WIDTH:     width_ff  <= eff_dim(csr_data[sbck_pkg::DIM_W-1:0]);
            sbck_pkg::CSR_HEIGHT:    height_ff <= eff_dim(csr_data[sbck_pkg::DIM_W-1:0]);
            sbck_pkg::CSR_FLIP:      flip_ff   <= csr_data[0];
            sbck_pkg::CSR_MASK:      mask_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         key_ff       <= '0;
      end else begin
         if (!req_stall) begin
            a_valid_ff <= req_valid && is_pixel;
         end
         if (adv_out) begin
            rsp_valid_ff <= rsp_valid_in;
         end
         if (a_fire) begin
            col_ff <= col_in;
            row_ff <= row_in;
            key_ff <= key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_pixel) begin
         a_index_ff <= req_payload.pixel_index;
      end
      if (a_fire && keep) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_done_wraps: assert property (@(posedge clock) disable iff (reset)
      (a_fire && done) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters did not return to zero after the last pixel");

   a_key_latch: assert property (@(posedge clock) disable iff (reset)
      (a_fire && first) |=> (key_ff == $past(a_index_ff)))
      else $error("key index not taken from the first pixel");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !adv_out) |=> (a_valid_ff && $stable(a_index_ff)
                                   && $stable(col_ff) && $stable(row_ff)))
      else $error("pixel stage changed while the response was stalled");

endmodule

`default_nettype wire
